// ===== hdl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the multilevel priority ready queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int ID_W     = 32;
	localparam int PRIO_W   = 3;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 4;
	localparam int ENTRY_W  = ID_W + PRIO_W;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_LEVELS = 1'b1;

	localparam logic [CFG_W-1:0] LEVELS_RST = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl
// Operation sequencer: accept, execute against the store, deliver result.
// ----------------------------------------------------------------------------
module mpq_ctrl import mpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
				if (s_tvalid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.load = sts.out_free;
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted word did not move to execute");
	a_finish_origin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> $past(state_q) == ST_EXEC || $past(state_q) == ST_FINISH)
		else $error("finish entered without execute");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.latch, cmd.exec, cmd.load}))
		else $error("overlapping datapath commands");
`endif

endmodule

// ===== hdl/mpq_dpath.sv =====
// ----------------------------------------------------------------------------
// mpq_dpath
// Config registers, per-level and single FIFO pointers, entry store, result.
// ----------------------------------------------------------------------------
module mpq_dpath import mpq_pkg::*; #(
	parameter int MAX_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [OP_W-1:0]      s_tuser,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int TOTAL = MAX_LEVELS * LEVEL_DEPTH;
	localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PW    = $clog2(LEVEL_DEPTH);
	localparam int CW    = $clog2(LEVEL_DEPTH + 1);
	localparam int AW    = $clog2(TOTAL);
	localparam int SCW   = $clog2(TOTAL + 1);

	// config
	logic             mode_q;
	logic [CFG_W-1:0] levels_q;
	logic [4:0]       act_lvls;
	logic             flush;

	// latched operation
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;

	// queue state
	logic [PW-1:0]  head_q [MAX_LEVELS];
	logic [PW-1:0]  tail_q [MAX_LEVELS];
	logic [CW-1:0]  cnt_q  [MAX_LEVELS];
	logic [AW-1:0]  sh_q, st_q;
	logic [SCW-1:0] sc_q;

	// execute decode
	logic          is_enq, is_take, is_rd;
	logic [7:0]    prio_ext;
	logic [LW-1:0] enq_lvl, sel_lvl, lvl;
	logic          sel_any, range_err, lvl_full, sf_full;
	logic [PW-1:0] head_nx, tail_nx;
	logic [AW-1:0] lvl_base;
	logic          ml_wr, ml_take, sf_wr, sf_take;

	// store
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// result
	logic                res_found_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_nx;
	logic [STATUS_W-1:0] res_status_nx;
	logic                out_valid_q;
	logic                out_found_q;
	logic [ID_W-1:0]     out_id_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [STATUS_W-1:0] out_status_q;

	assign flush = cfg_we && (cfg_index == CFG_MODE) && (cfg_data[0] != mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			levels_q <= LEVELS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_LEVELS: levels_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign act_lvls = ({1'b0, levels_q} > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : {1'b0, levels_q};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= s_tuser;
			id_q   <= s_tdata[ID_W-1:0];
			prio_q <= s_tdata[ID_W+PRIO_W-1:ID_W];
		end
	end

	assign is_enq  = (op_q == OP_ENQ);
	assign is_take = (op_q == OP_DEQ);
	assign is_rd   = (op_q == OP_DEQ) || (op_q == OP_PEEK);

	assign prio_ext = {5'b0, prio_q};
	assign enq_lvl  = prio_ext[LW-1:0];

	// lowest-numbered non-empty level in use
	always_comb begin
		sel_lvl = '0;
		sel_any = 1'b0;
		for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
			if ((cnt_q[l] != '0) && (5'(l) < act_lvls)) begin
				sel_lvl = LW'(l);
				sel_any = 1'b1;
			end
		end
	end

	assign lvl       = is_enq ? enq_lvl : sel_lvl;
	assign range_err = {2'b0, prio_q} >= act_lvls;
	assign lvl_full  = cnt_q[lvl] == CW'(LEVEL_DEPTH);
	assign sf_full   = sc_q == SCW'(TOTAL);
	assign head_nx   = (head_q[lvl] == PW'(LEVEL_DEPTH - 1)) ? '0 : head_q[lvl] + 1'b1;
	assign tail_nx   = (tail_q[lvl] == PW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[lvl] + 1'b1;
	assign lvl_base  = AW'(lvl) * AW'(LEVEL_DEPTH);

	assign ml_wr   = cmd.exec && mode_q && is_enq && !range_err && !lvl_full;
	assign ml_take = cmd.exec && mode_q && is_take && sel_any;
	assign sf_wr   = cmd.exec && !mode_q && is_enq && !sf_full;
	assign sf_take = cmd.exec && !mode_q && is_take && (sc_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < MAX_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else if (flush) begin
			for (int l = 0; l < MAX_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else if (ml_wr) begin
			tail_q[lvl] <= tail_nx;
			cnt_q[lvl]  <= cnt_q[lvl] + 1'b1;
		end else if (ml_take) begin
			head_q[lvl] <= head_nx;
			cnt_q[lvl]  <= cnt_q[lvl] - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
			st_q <= '0;
			sc_q <= '0;
		end else if (flush) begin
			sh_q <= '0;
			st_q <= '0;
			sc_q <= '0;
		end else if (sf_wr) begin
			st_q <= (st_q == AW'(TOTAL - 1)) ? '0 : st_q + 1'b1;
			sc_q <= sc_q + 1'b1;
		end else if (sf_take) begin
			sh_q <= (sh_q == AW'(TOTAL - 1)) ? '0 : sh_q + 1'b1;
			sc_q <= sc_q - 1'b1;
		end
	end

	assign ram_we    = ml_wr || sf_wr;
	assign ram_waddr = mode_q ? lvl_base + AW'(tail_q[lvl]) : st_q;
	assign ram_re    = cmd.exec && is_rd;
	assign ram_raddr = mode_q ? lvl_base + AW'(head_q[lvl]) : sh_q;

	mpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TOTAL)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({prio_q, id_q}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_found_nx  = 1'b0;
		res_status_nx = STS_OK;
		case (op_q)
			OP_ENQ: begin
				if (mode_q) begin
					if (range_err) begin
						res_status_nx = STS_RANGE;
					end else if (lvl_full) begin
						res_status_nx = STS_FULL;
					end
				end else if (sf_full) begin
					res_status_nx = STS_FULL;
				end
			end
			OP_DEQ, OP_PEEK: begin
				res_found_nx  = mode_q ? sel_any : (sc_q != '0);
				res_status_nx = res_found_nx ? STS_OK : STS_EMPTY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_found_q  <= res_found_nx;
			res_status_q <= res_status_nx;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_found_q  <= res_found_q;
			out_id_q     <= res_found_q ? ram_rdata[ID_W-1:0] : '0;
			out_prio_q   <= res_found_q ? ram_rdata[ENTRY_W-1:ID_W] : '0;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, out_status_q, out_prio_q, out_id_q, out_found_q};

`ifndef SYNTH
	a_sf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= SCW'(TOTAL))
		else $error("single FIFO count beyond capacity");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> sc_q == '0 && cnt_q[0] == '0)
		else $error("mode change left queue entries");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_found_q |-> out_status_q == STS_OK)
		else $error("entry returned with error status");
`endif

endmodule

// ===== hdl/multilevel_priority_ready_queue_core.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue_core
// Ready queue for a task scheduler: strict priority levels or one FIFO.
//
// channel  dir  handshake            content
// s_       in   s_tvalid/s_tready    tuser opcode, tdata task_id, priority_req
// m_       out  m_tvalid/m_tready    tdata found, task id, priority, status
// cfg_     in   cfg_we               cfg_index 0 mode, 1 level count
//
// Each word passes through accept, store access and result in turn; the
// registered read of the entry store puts the result after the access.
// The output register frees the input side: a new word is taken while a
// result waits. The entry store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queue_core import mpq_pkg::*; #(
	parameter int MAX_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // task_id, priority_req, zero pad
	input  logic [OP_W-1:0]      s_tuser,  // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // found, out_task_id, out_priority, status, pad
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	mpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mpq_dpath #(
		.MAX_LEVELS (MAX_LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
